// File: hdl/pprc_pkg.sv
// ----------------------------------------------------------------------------
// pprc_pkg
// Shared constants, state types and the status struct of the prime power range
// counter.
// ----------------------------------------------------------------------------
package pprc_pkg;

	localparam int SIEVE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(SIEVE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SIEVE_MAX   = SIEVE_DEPTH - 1;

	localparam int DATA_W  = 32;
	localparam int ROOT_W  = DATA_W / 2;
	localparam int ROOT_IT = DATA_W / 2;
	localparam int PROD_W  = DATA_W + ADDR_W;

	localparam int COUNT_W = 13;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		TOP_IDLE,
		TOP_ROOT,
		TOP_SIEVE,
		TOP_DRAIN
	} top_state_t;

	typedef enum logic [3:0] {
		SV_IDLE,
		SV_INIT,
		SV_MARK_RD,
		SV_MARK_CHK,
		SV_STRIKE,
		SV_SCAN_RD,
		SV_SCAN_CHK,
		SV_OFFER,
		SV_DONE
	} sv_state_t;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_MUL,
		WK_CHK
	} wk_state_t;

	// sieve to sequencer
	typedef struct packed {
		logic prime_valid;
		logic done;
	} sv_status_t;

endpackage

// File: hdl/pprc_isqrt.sv
// ----------------------------------------------------------------------------
// pprc_isqrt
// Exact floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module pprc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pprc_pkg::DATA_W-1:0]  value,
	output logic                         done,
	output logic [pprc_pkg::ROOT_W-1:0]  root
);
	import pprc_pkg::*;

	localparam logic [DATA_W-1:0] TOP_BIT = DATA_W'(1) << (DATA_W - 2);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] root_q;
	logic [DATA_W-1:0] bit_q;
	logic              run_q;
	logic              done_q;
	logic [DATA_W-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q == DATA_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= value;
			root_q <= '0;
			bit_q  <= TOP_BIT;
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[ROOT_W-1:0];

endmodule

// File: hdl/pprc_sieve.sv
// ----------------------------------------------------------------------------
// pprc_sieve
// Flag memory with the sieve sequencer: fill, strike composites, then scan
// and offer each prime in ascending order.
// ----------------------------------------------------------------------------
module pprc_sieve (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pprc_pkg::ADDR_W-1:0]  extent,
	input  logic                         prime_take,
	output pprc_pkg::sv_status_t         status,
	output logic [pprc_pkg::ADDR_W-1:0]  prime
);
	import pprc_pkg::*;

	logic flag_mem [SIEVE_DEPTH];

	sv_state_t         state_q, state_d;
	logic [ADDR_W-1:0] ext_q;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  sq_q, sq_d;
	logic [CNT_W-1:0]  mul_q, mul_d;
	logic [CNT_W-1:0]  ext_w;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic              wdata;
	logic [ADDR_W-1:0] raddr;
	logic              rdata_q;

	logic [CNT_W:0]    sq_next;

	assign ext_w = {1'b0, ext_q};
	// (i+1)^2 = i^2 + 2i + 1
	assign sq_next = {1'b0, sq_q} + {idx_q, 1'b1};

	always_ff @(posedge clk) begin
		if (we) begin
			flag_mem[waddr] <= wdata;
		end
		rdata_q <= flag_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ext_q <= extent;
		end
		idx_q <= idx_d;
		sq_q  <= sq_d;
		mul_q <= mul_d;
	end

	always_comb begin
		state_d            = state_q;
		idx_d              = idx_q;
		sq_d               = sq_q;
		mul_d              = mul_q;
		we                 = 1'b0;
		waddr              = idx_q[ADDR_W-1:0];
		wdata              = 1'b0;
		raddr              = idx_q[ADDR_W-1:0];
		status.prime_valid = 1'b0;
		status.done        = 1'b0;
		case (state_q)
			SV_IDLE: begin
				if (start) begin
					idx_d   = '0;
					state_d = SV_INIT;
				end
			end
			SV_INIT: begin
				we    = 1'b1;
				wdata = (idx_q >= CNT_W'(2));
				if (idx_q == ext_w) begin
					idx_d   = CNT_W'(2);
					sq_d    = CNT_W'(4);
					state_d = SV_MARK_RD;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			SV_MARK_RD: begin
				if (sq_q > ext_w) begin
					idx_d   = CNT_W'(2);
					state_d = SV_SCAN_RD;
				end else begin
					state_d = SV_MARK_CHK;
				end
			end
			SV_MARK_CHK: begin
				if (rdata_q) begin
					mul_d   = sq_q;
					state_d = SV_STRIKE;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					sq_d    = sq_next[CNT_W-1:0];
					state_d = SV_MARK_RD;
				end
			end
			SV_STRIKE: begin
				waddr = mul_q[ADDR_W-1:0];
				if (mul_q > ext_w) begin
					idx_d   = idx_q + CNT_W'(1);
					sq_d    = sq_next[CNT_W-1:0];
					state_d = SV_MARK_RD;
				end else begin
					we    = 1'b1;
					mul_d = mul_q + idx_q;
				end
			end
			SV_SCAN_RD: begin
				if (idx_q > ext_w) begin
					state_d = SV_DONE;
				end else begin
					state_d = SV_SCAN_CHK;
				end
			end
			SV_SCAN_CHK: begin
				if (rdata_q) begin
					state_d = SV_OFFER;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = SV_SCAN_RD;
				end
			end
			SV_OFFER: begin
				status.prime_valid = 1'b1;
				if (prime_take) begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = SV_SCAN_RD;
				end
			end
			SV_DONE: begin
				status.done = 1'b1;
				state_d     = SV_IDLE;
			end
			default: begin
				state_d = SV_IDLE;
			end
		endcase
	end

	assign prime = idx_q[ADDR_W-1:0];

endmodule

// File: hdl/pprc_walk.sv
// ----------------------------------------------------------------------------
// pprc_walk
// Walks p^2, p^3, ... up to the upper bound and counts powers in range.
// ----------------------------------------------------------------------------
module pprc_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          take,
	input  logic [pprc_pkg::ADDR_W-1:0]   prime,
	input  logic [pprc_pkg::DATA_W-1:0]   range_low,
	input  logic [pprc_pkg::DATA_W-1:0]   range_high,
	output logic                          idle,
	output logic [pprc_pkg::COUNT_W-1:0]  count
);
	import pprc_pkg::*;

	wk_state_t          state_q;
	logic [ADDR_W-1:0]  p_q;
	logic [DATA_W-1:0]  pw_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COUNT_W-1:0] count_q;
	logic               in_range;

	assign in_range = (prod_q <= PROD_W'(range_high));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WK_IDLE;
			count_q <= '0;
		end else begin
			if (clear) begin
				count_q <= '0;
			end
			case (state_q)
				WK_IDLE: begin
					if (take) begin
						state_q <= WK_MUL;
					end
				end
				WK_MUL: begin
					state_q <= WK_CHK;
				end
				WK_CHK: begin
					if (in_range) begin
						if (prod_q >= PROD_W'(range_low) && count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_W'(1);
						end
						state_q <= WK_MUL;
					end else begin
						state_q <= WK_IDLE;
					end
				end
				default: begin
					state_q <= WK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == WK_IDLE && take) begin
			p_q  <= prime;
			pw_q <= DATA_W'(prime);
		end
		if (state_q == WK_MUL) begin
			prod_q <= PROD_W'(pw_q) * PROD_W'(p_q);
		end
		if (state_q == WK_CHK) begin
			pw_q <= prod_q[DATA_W-1:0];
		end
	end

	assign idle  = (state_q == WK_IDLE);
	assign count = count_q;

endmodule

// File: hdl/prime_power_range_counter_core.sv
// ----------------------------------------------------------------------------
// prime_power_range_counter_core
// Counts prime powers p^k, k >= 2, in [range_low, range_high] using a sieve
// rebuilt for each item in a flag memory with one write port and one read port.
// ----------------------------------------------------------------------------
// Sequence: square root, fill of extent+1 flags, sieving of candidates with
//   strikes of the multiples of each sieving prime, then the scan that offers
//   each prime; power walks mostly hide under the scan.
// Throughput: one item at a time; busy falls as done pulses with power_count; the
//   receiver cannot stall. Reset clears control only; flags are rewritten per item.
module prime_power_range_counter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pprc_pkg::DATA_W-1:0]   range_low,
	input  logic [pprc_pkg::DATA_W-1:0]   range_high,
	output logic                          done,
	output logic [pprc_pkg::COUNT_W-1:0]  power_count
);
	import pprc_pkg::*;

	top_state_t         state_q, state_d;
	logic [DATA_W-1:0]  lo_q;
	logic [DATA_W-1:0]  hi_q;
	logic               done_q;
	logic [COUNT_W-1:0] power_count_q;

	logic               accept;
	logic               root_done;
	logic [ROOT_W-1:0]  root;
	logic [ADDR_W-1:0]  extent;
	logic               sieve_start;
	sv_status_t         sv_status;
	logic [ADDR_W-1:0]  prime;
	logic               prime_take;
	logic               walk_idle;
	logic [COUNT_W-1:0] walk_count;
	logic               report;

	assign accept = start && (state_q == TOP_IDLE);

	// clamp to the top entry of the flag memory
	assign extent = (DATA_W'(root) > DATA_W'(SIEVE_MAX)) ? ADDR_W'(SIEVE_MAX)
	                                                     : ADDR_W'(root);

	assign prime_take = sv_status.prime_valid && walk_idle;

	pprc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (range_high),
		.done   (root_done),
		.root   (root)
	);

	pprc_sieve u_sieve (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (sieve_start),
		.extent     (extent),
		.prime_take (prime_take),
		.status     (sv_status),
		.prime      (prime)
	);

	pprc_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.take       (prime_take),
		.prime      (prime),
		.range_low  (lo_q),
		.range_high (hi_q),
		.idle       (walk_idle),
		.count      (walk_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= report;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= range_low;
			hi_q <= range_high;
		end
		if (report) begin
			power_count_q <= walk_count;
		end
	end

	always_comb begin
		state_d     = state_q;
		sieve_start = 1'b0;
		report      = 1'b0;
		case (state_q)
			TOP_IDLE: begin
				if (start) begin
					state_d = TOP_ROOT;
				end
			end
			TOP_ROOT: begin
				if (root_done) begin
					sieve_start = 1'b1;
					state_d     = TOP_SIEVE;
				end
			end
			TOP_SIEVE: begin
				if (sv_status.done) begin
					state_d = TOP_DRAIN;
				end
			end
			TOP_DRAIN: begin
				// last prime may still be walking
				if (walk_idle) begin
					report  = 1'b1;
					state_d = TOP_IDLE;
				end
			end
			default: begin
				state_d = TOP_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != TOP_IDLE);
	assign done        = done_q;
	assign power_count = power_count_q;

endmodule

// File: verif/pprc_checker.sv
// ----------------------------------------------------------------------------
// pprc_checker
// Watches the query and result channels of the prime power range counter,
// predicts each count with its own sieve and compares results in order.
// ----------------------------------------------------------------------------
module pprc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [pprc_pkg::DATA_W-1:0]   range_low,
	input  logic [pprc_pkg::DATA_W-1:0]   range_high,
	input  logic                          done,
	input  logic [pprc_pkg::COUNT_W-1:0]  power_count,
	output int                            mismatch_count,
	output int                            pending_count
);

	bit prime_flags [pprc_pkg::SIEVE_DEPTH];
	logic [pprc_pkg::COUNT_W-1:0] expected_counts [$];

	// largest r with r*r <= v, built one root bit at a time
	function automatic int floor_root(input logic [pprc_pkg::DATA_W-1:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = pprc_pkg::ROOT_W - 1; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= 64'(v))
				root = trial;
		end
		return int'(root);
	endfunction

	function automatic logic [pprc_pkg::COUNT_W-1:0] count_prime_powers(
		input logic [pprc_pkg::DATA_W-1:0] lo,
		input logic [pprc_pkg::DATA_W-1:0] hi
	);
		int extent;
		logic [63:0] pw;
		logic [pprc_pkg::COUNT_W-1:0] total;
		extent = floor_root(hi);
		if (extent > pprc_pkg::SIEVE_MAX)
			extent = pprc_pkg::SIEVE_MAX;
		for (int i = 0; i <= extent; i++)
			prime_flags[i] = (i >= 2);
		for (int i = 2; i * i <= extent; i++) begin
			if (prime_flags[i]) begin
				for (int m = i * i; m <= extent; m += i)
					prime_flags[m] = 1'b0;
			end
		end
		total = '0;
		for (int p = 2; p <= extent; p++) begin
			if (prime_flags[p]) begin
				pw = 64'(p) * 64'(p);
				while (pw <= 64'(hi)) begin
					if (pw >= 64'(lo) && total != pprc_pkg::COUNT_MAX)
						total++;
					pw = pw * 64'(p);
				end
			end
		end
		return total;
	endfunction

	task automatic note_mismatch(
		input string what,
		input logic [pprc_pkg::COUNT_W-1:0] want,
		input logic [pprc_pkg::COUNT_W-1:0] got
	);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH %s: expected power_count %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin : watch
		logic [pprc_pkg::COUNT_W-1:0] want;
		if (arst_n) begin
			if (done) begin
				if (expected_counts.size() == 0) begin
					note_mismatch("unexpected result", '0, power_count);
				end else begin
					want = expected_counts.pop_front();
					if (power_count !== want)
						note_mismatch("power_count", want, power_count);
				end
			end
			if (start && !busy)
				expected_counts.push_back(count_prime_powers(range_low, range_high));
			pending_count = expected_counts.size();
		end
	end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random range queries into the prime power range counter
// under several sender idle rates; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [pprc_pkg::DATA_W-1:0]   range_low = '0;
	logic [pprc_pkg::DATA_W-1:0]   range_high = '0;
	logic                          done;
	logic [pprc_pkg::COUNT_W-1:0]  power_count;
	int                            mismatch_count;
	int                            pending_count;
	int                            idle_pct = 0;

	always #5 clk = ~clk;

	prime_power_range_counter_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.range_low   (range_low),
		.range_high  (range_high),
		.done        (done),
		.power_count (power_count)
	);

	pprc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.range_low      (range_low),
		.range_high     (range_high),
		.done           (done),
		.power_count    (power_count),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// holds start until the query is taken, then maybe drops it for a while
	task automatic issue_query(
		input logic [pprc_pkg::DATA_W-1:0] lo,
		input logic [pprc_pkg::DATA_W-1:0] hi
	);
		int gap;
		range_low  <= lo;
		range_high <= hi;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 200)
			gap++;
		if (gap > 0) begin
			start      <= 1'b0;
			range_low  <= $urandom;
			range_high <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_random_query();
		int hi_bits;
		logic [31:0] hi;
		logic [31:0] lo;
		// keep most queries small; a wide high bound costs a long sieve
		if ($urandom_range(49) == 0)
			hi_bits = $urandom_range(26, 21);
		else
			hi_bits = $urandom_range(20, 1);
		hi = $urandom & ((32'd1 << hi_bits) - 1);
		case ($urandom_range(9))
			0, 1:    lo = '0;
			2, 3:    lo = $urandom;
			default: lo = $urandom_range(hi, 0);
		endcase
		issue_query(lo, hi);
	endtask

	initial begin
		int phase_idle [4] = '{0, 62, 0, 14};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_query(32'd1, 32'd1);
		issue_query(32'd0, 32'd0);
		issue_query(32'd0, 32'd4);
		issue_query(32'd4, 32'd4);
		issue_query(32'd5, 32'd7);
		issue_query(32'd8, 32'd9);
		issue_query(32'd1, 32'd24);
		issue_query(32'd1, 32'd25);
		issue_query(32'd26, 32'd27);
		issue_query(32'd1, 32'd100);
		issue_query(32'd50, 32'd10);             // low above high
		issue_query(32'hFFFF_FFFF, 32'd16);      // low above high, all low bits set
		issue_query(32'd0, 32'd65536);
		issue_query(32'd65536, 32'd65536);
		issue_query(32'd0, 32'hFFFF_FFFF);       // full sieve extent
		issue_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		foreach (phase_idle[ph]) begin
			idle_pct = phase_idle[ph];
			repeat (25) issue_random_query();
		end
		start <= 1'b0;

		do @(negedge clk); while (pending_count != 0);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
